[rtl/pidfd_pkg.sv]
// Package for the PID controller with filtered derivative.
// Holds the datapath operation codes, controller/datapath structs and the
// Q16.16 round-and-saturate helper. No dependencies.
`default_nettype none

package pidfd_pkg;

    localparam int unsigned OP_W = 4;

    localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
    localparam logic [OP_W-1:0] OP_DIFF   = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL_D  = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL_I  = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL_P  = 4'd5;
    localparam logic [OP_W-1:0] OP_FILT_A = 4'd6;
    localparam logic [OP_W-1:0] OP_FILT_B = 4'd7;
    localparam logic [OP_W-1:0] OP_FILT_C = 4'd8;
    localparam logic [OP_W-1:0] OP_SUM    = 4'd9;
    localparam logic [OP_W-1:0] OP_OUT    = 4'd10;

    localparam logic [2:0] REG_GAIN_P       = 3'd0;
    localparam logic [2:0] REG_GAIN_I       = 3'd1;
    localparam logic [2:0] REG_GAIN_D       = 3'd2;
    localparam logic [2:0] REG_INT_BOUND    = 3'd3;
    localparam logic [2:0] REG_DRIVE_UPPER  = 3'd4;
    localparam logic [2:0] REG_DRIVE_LOWER  = 3'd5;
    localparam logic [2:0] REG_SMOOTH_COEFF = 3'd6;
    localparam logic [2:0] REG_DEAD_BAND    = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic filt_off;
    } sts_t;

    // Q32.32 product to Q16.16: add half an LSB, floor, saturate to 32 bits
    function automatic logic [31:0] round_sat(input logic signed [65:0] x);
        logic signed [65:0] t;
        logic signed [65:0] s;
        t = x + 66'sd32768;
        s = t >>> 16;
        if (s > 66'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (s < -66'sd2147483648)
            return 32'h8000_0000;
        else
            return s[31:0];
    endfunction

endpackage

`default_nettype wire

[rtl/pidfd_ctrl.sv]
// Sequencer for the PID controller: walks one item through the shared
// multiplier schedule and owns the result valid flag.
// Depends on pidfd_pkg.
`default_nettype none

module pidfd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            sample_valid,
    output logic                 sample_ready,
    input  wire logic            action,
    output logic                 result_valid,
    input  wire logic            result_ready,
    input  wire pidfd_pkg::sts_t sts,
    output pidfd_pkg::cmd_t      cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIFF   = 4'd1;
    localparam logic [3:0] ST_MUL_D  = 4'd2;
    localparam logic [3:0] ST_MUL_I  = 4'd3;
    localparam logic [3:0] ST_MUL_P  = 4'd4;
    localparam logic [3:0] ST_FILT_A = 4'd5;
    localparam logic [3:0] ST_FILT_B = 4'd6;
    localparam logic [3:0] ST_FILT_C = 4'd7;
    localparam logic [3:0] ST_SUM    = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       valid_reg;
    logic       valid_next;

    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg && !result_ready;
        cmd.op       = pidfd_pkg::OP_NONE;
        sample_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.op     = pidfd_pkg::OP_LOAD;
                    state_next = action ? ST_OUT : ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.op     = pidfd_pkg::OP_DIFF;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.op     = pidfd_pkg::OP_MUL_D;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.op     = pidfd_pkg::OP_MUL_I;
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.op     = pidfd_pkg::OP_MUL_P;
                state_next = ST_FILT_A;
            end
            ST_FILT_A:
            begin
                cmd.op     = pidfd_pkg::OP_FILT_A;
                state_next = sts.filt_off ? ST_SUM : ST_FILT_B;
            end
            ST_FILT_B:
            begin
                cmd.op     = pidfd_pkg::OP_FILT_B;
                state_next = ST_FILT_C;
            end
            ST_FILT_C:
            begin
                cmd.op     = pidfd_pkg::OP_FILT_C;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op     = pidfd_pkg::OP_SUM;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!valid_reg || result_ready)
                begin
                    cmd.op     = pidfd_pkg::OP_OUT;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;

endmodule

`default_nettype wire

[rtl/pidfd_dp.sv]
// Datapath for the PID controller: configuration registers, controller
// state, one shared 33x33 multiplier and the output register.
// Depends on pidfd_pkg.
`default_nettype none

module pidfd_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pidfd_pkg::cmd_t cmd,
    output pidfd_pkg::sts_t      sts,
    input  wire logic            cfg_valid,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [31:0]     cfg_data,
    input  wire logic            action,
    input  wire logic [31:0]     error_sample,
    input  wire logic            integral_hold,
    output logic [31:0]          drive,
    output logic                 drive_clamped
);

    logic signed [31:0] gain_p_reg;
    logic signed [31:0] gain_i_reg;
    logic signed [31:0] gain_d_reg;
    logic [30:0]        int_bound_reg;
    logic signed [31:0] drive_upper_reg;
    logic signed [31:0] drive_lower_reg;
    logic [15:0]        smooth_reg;
    logic [30:0]        dead_band_reg;

    logic signed [31:0] prev_err_reg;
    logic signed [31:0] integ_reg;
    logic signed [31:0] deriv_last_reg;

    logic signed [31:0] err_reg;
    logic               hold_reg;
    logic               clr_reg;
    logic signed [32:0] diff_reg;
    logic signed [65:0] prod_reg;
    logic signed [65:0] prod2_reg;
    logic signed [31:0] raw_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] d_reg;
    logic signed [33:0] sum_reg;
    logic [31:0]        drive_reg;
    logic               clamped_reg;

    logic signed [32:0] band_ext;
    logic signed [32:0] err_ext;
    logic signed [32:0] dz_wide;
    logic signed [31:0] dz_val;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic [16:0]        coeff_rest;
    logic signed [31:0] term_round;
    logic signed [32:0] acc;
    logic signed [32:0] bnd;
    logic signed [32:0] integ_next;
    logic signed [65:0] filt_sum;
    logic signed [31:0] filt_val;
    logic signed [33:0] upper_ext;
    logic signed [33:0] lower_ext;
    logic [31:0]        drive_next;
    logic               clamped_next;

    // deadzone
    always_comb
    begin
        band_ext = $signed({2'b00, dead_band_reg});
        err_ext  = {error_sample[31], error_sample};
        if (dead_band_reg == 31'd0)
            dz_wide = err_ext;
        else if (err_ext <= band_ext && err_ext >= -band_ext)
            dz_wide = 33'sd0;
        else if (err_ext > band_ext)
            dz_wide = err_ext - band_ext;
        else
            dz_wide = err_ext + band_ext;
        dz_val = dz_wide[31:0];
    end

    // shared multiplier operand select
    always_comb
    begin
        coeff_rest = 17'h10000 - {1'b0, smooth_reg};
        mul_a      = 33'sd0;
        mul_b      = 33'sd0;
        case (cmd.op)
            pidfd_pkg::OP_MUL_D:
            begin
                mul_a = {gain_d_reg[31], gain_d_reg};
                mul_b = diff_reg;
            end
            pidfd_pkg::OP_MUL_I:
            begin
                mul_a = {gain_i_reg[31], gain_i_reg};
                mul_b = {err_reg[31], err_reg};
            end
            pidfd_pkg::OP_MUL_P:
            begin
                mul_a = {gain_p_reg[31], gain_p_reg};
                mul_b = {err_reg[31], err_reg};
            end
            pidfd_pkg::OP_FILT_A:
            begin
                mul_a = {raw_reg[31], raw_reg};
                mul_b = $signed({16'd0, coeff_rest});
            end
            pidfd_pkg::OP_FILT_B:
            begin
                mul_a = {deriv_last_reg[31], deriv_last_reg};
                mul_b = $signed({17'd0, smooth_reg});
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // integrator step, derivative filter, output clamp
    always_comb
    begin
        term_round = pidfd_pkg::round_sat(prod_reg);
        acc        = {integ_reg[31], integ_reg} + {term_round[31], term_round};
        bnd        = $signed({2'b00, int_bound_reg});
        if (acc > bnd)
            integ_next = bnd;
        else if (acc < -bnd)
            integ_next = -bnd;
        else
            integ_next = acc;

        filt_sum = prod_reg + prod2_reg;
        filt_val = pidfd_pkg::round_sat(filt_sum);

        upper_ext = {{2{drive_upper_reg[31]}}, drive_upper_reg};
        lower_ext = {{2{drive_lower_reg[31]}}, drive_lower_reg};
        if (clr_reg)
        begin
            drive_next   = 32'd0;
            clamped_next = 1'b0;
        end
        else if (sum_reg > upper_ext)
        begin
            drive_next   = drive_upper_reg;
            clamped_next = 1'b1;
        end
        else if (sum_reg < lower_ext)
        begin
            drive_next   = drive_lower_reg;
            clamped_next = 1'b1;
        end
        else
        begin
            drive_next   = sum_reg[31:0];
            clamped_next = 1'b0;
        end
    end

    // configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg      <= 32'sd0;
            gain_i_reg      <= 32'sd0;
            gain_d_reg      <= 32'sd0;
            int_bound_reg   <= 31'd0;
            drive_upper_reg <= 32'sh7FFF_FFFF;
            drive_lower_reg <= 32'sh8000_0000;
            smooth_reg      <= 16'd0;
            dead_band_reg   <= 31'd0;
            prev_err_reg    <= 32'sd0;
            integ_reg       <= 32'sd0;
            deriv_last_reg  <= 32'sd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    pidfd_pkg::REG_GAIN_P:       gain_p_reg      <= cfg_data;
                    pidfd_pkg::REG_GAIN_I:       gain_i_reg      <= cfg_data;
                    pidfd_pkg::REG_GAIN_D:       gain_d_reg      <= cfg_data;
                    pidfd_pkg::REG_INT_BOUND:    int_bound_reg   <= cfg_data[30:0];
                    pidfd_pkg::REG_DRIVE_UPPER:  drive_upper_reg <= cfg_data;
                    pidfd_pkg::REG_DRIVE_LOWER:  drive_lower_reg <= cfg_data;
                    pidfd_pkg::REG_SMOOTH_COEFF: smooth_reg      <= cfg_data[15:0];
                    pidfd_pkg::REG_DEAD_BAND:    dead_band_reg   <= cfg_data[30:0];
                    default:                     gain_p_reg      <= gain_p_reg;
                endcase
            end
            case (cmd.op)
                pidfd_pkg::OP_LOAD:
                begin
                    if (action)
                    begin
                        prev_err_reg   <= 32'sd0;
                        integ_reg      <= 32'sd0;
                        deriv_last_reg <= 32'sd0;
                    end
                end
                pidfd_pkg::OP_DIFF:
                begin
                    prev_err_reg <= err_reg;
                end
                pidfd_pkg::OP_MUL_P:
                begin
                    if (!hold_reg)
                        integ_reg <= integ_next[31:0];
                end
                pidfd_pkg::OP_FILT_C:
                begin
                    deriv_last_reg <= filt_val;
                end
                default:
                begin
                    integ_reg <= integ_reg;
                end
            endcase
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pidfd_pkg::OP_LOAD:
            begin
                err_reg  <= dz_val;
                hold_reg <= integral_hold;
                clr_reg  <= action;
            end
            pidfd_pkg::OP_DIFF:
            begin
                diff_reg <= {err_reg[31], err_reg} - {prev_err_reg[31], prev_err_reg};
            end
            pidfd_pkg::OP_MUL_D:
            begin
                prod_reg <= mul_p;
            end
            pidfd_pkg::OP_MUL_I:
            begin
                raw_reg  <= term_round;
                prod_reg <= mul_p;
            end
            pidfd_pkg::OP_MUL_P:
            begin
                prod_reg <= mul_p;
            end
            pidfd_pkg::OP_FILT_A:
            begin
                p_reg    <= term_round;
                d_reg    <= raw_reg;
                prod_reg <= mul_p;
            end
            pidfd_pkg::OP_FILT_B:
            begin
                prod2_reg <= mul_p;
            end
            pidfd_pkg::OP_FILT_C:
            begin
                d_reg <= filt_val;
            end
            pidfd_pkg::OP_SUM:
            begin
                sum_reg <= {{2{p_reg[31]}}, p_reg} + {{2{integ_reg[31]}}, integ_reg}
                           + {{2{d_reg[31]}}, d_reg};
            end
            pidfd_pkg::OP_OUT:
            begin
                drive_reg   <= drive_next;
                clamped_reg <= clamped_next;
            end
            default:
            begin
                hold_reg <= hold_reg;
            end
        endcase
    end

    assign sts.filt_off   = (smooth_reg == 16'd0);
    assign drive          = drive_reg;
    assign drive_clamped  = clamped_reg;

endmodule

`default_nettype wire

[rtl/pid_controller_filtered_derivative.sv]
// Top level of the positional PID controller with error deadzone, held
// integrator and low-pass filtered derivative. Depends on pidfd_pkg,
// pidfd_ctrl and pidfd_dp.
//
// One item at a time. A step item runs the difference, derivative,
// integral and proportional products, filter steps A to C (B and C only
// with the filter on), sum and output; a clear item goes straight to
// output. The single shared 33x33 multiplier is used once each for the
// three terms and twice more for the filter. A finished result waits in
// the output register while the next item is accepted. The configuration
// port is always ready; write it only while the block is idle.
`default_nettype none

module pid_controller_filtered_derivative (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sample_valid,
    output logic             sample_ready,
    input  wire logic        action,
    input  wire logic [31:0] error_sample,
    input  wire logic        integral_hold,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [31:0]      drive,
    output logic             drive_clamped,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    pidfd_pkg::cmd_t cmd;
    pidfd_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    pidfd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .action       (action),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    pidfd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .error_sample  (error_sample),
        .integral_hold (integral_hold),
        .drive         (drive),
        .drive_clamped (drive_clamped)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample_ready stayed high after an item was accepted");

    a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> sample_ready)
        else $error("result posted while the sequencer is still busy");

    a_busy_only_on_item: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sample_ready) |-> $past(sample_valid))
        else $error("sequencer left idle without an item");
`endif

endmodule

`default_nettype wire

[sim/pid_drive_checker.sv]
// Checker for the filtered-derivative PID controller: watches the config,
// sample and result channels, predicts each drive value and compares it.
// Depends on pidfd_pkg for the register indexes.
`timescale 1ns / 100ps

module pid_drive_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sample_valid,
    input  wire logic        sample_ready,
    input  wire logic        action,
    input  wire logic [31:0] error_sample,
    input  wire logic        integral_hold,
    input  wire logic        result_valid,
    input  wire logic        result_ready,
    input  wire logic [31:0] drive,
    input  wire logic        drive_clamped,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               errors,
    output int               checked,
    output int               outstanding,
    output int               clamp_hits
);

    typedef struct packed {
        logic [31:0] level;
        logic        clamped;
    } drive_t;

    logic signed [31:0] kp, ki, kd, hi_lim, lo_lim;
    logic        [30:0] int_lim, band;
    logic        [15:0] alpha;
    logic signed [31:0] last_err, integ, deriv_mem;
    drive_t             drive_q[$];

    function automatic logic signed [31:0] q16_sat(input logic signed [65:0] prod);
        logic signed [65:0] scaled;
        scaled = (prod + 66'sd32768) >>> 16;
        if (scaled[65:31] != {35{scaled[65]}})
            return scaled[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return scaled[31:0];
    endfunction

    task automatic compute_drive(input logic clear, input logic signed [31:0] err_in,
                                 input logic hold, output drive_t res);
        longint             e, lim, acc, sum;
        logic signed [31:0] raw, d_term, p_term;
        logic signed [65:0] wa, wb, wc, wd;
        res = '0;
        if (clear) begin
            last_err  = '0;
            integ     = '0;
            deriv_mem = '0;
            return;
        end
        e   = err_in;
        lim = longint'(band);
        if (lim != 0) begin
            if (e <= lim && e >= -lim)
                e = 0;
            else if (e > lim)
                e = e - lim;
            else
                e = e + lim;
        end

        wa = kd;
        wb = e - longint'(last_err);
        raw = q16_sat(wa * wb);
        last_err = e[31:0];

        if (!hold) begin
            wa  = ki;
            wb  = e;
            acc = longint'(integ) + longint'(q16_sat(wa * wb));
            lim = longint'(int_lim);
            if (acc > lim)
                acc = lim;
            else if (acc < -lim)
                acc = -lim;
            integ = acc[31:0];
        end

        if (alpha != 0) begin
            wa = raw;
            wc = deriv_mem;
            wd = {50'd0, alpha};
            wb = 66'sd65536 - wd;
            deriv_mem = q16_sat(wa * wb + wc * wd);
            d_term = deriv_mem;
        end else begin
            d_term = raw;
        end

        wa = kp;
        wb = e;
        p_term = q16_sat(wa * wb);
        sum = longint'(p_term) + longint'(integ) + longint'(d_term);
        if (sum > longint'(hi_lim)) begin
            res.level   = hi_lim;
            res.clamped = 1'b1;
        end else if (sum < longint'(lo_lim)) begin
            res.level   = lo_lim;
            res.clamped = 1'b1;
        end else begin
            res.level = sum[31:0];
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        drive_t want;
        drive_t got;
        int     bad;
        int     done;
        if (!rst_n) begin
            kp          = '0;
            ki          = '0;
            kd          = '0;
            int_lim     = '0;
            hi_lim      = 32'sh7FFF_FFFF;
            lo_lim      = 32'sh8000_0000;
            alpha       = '0;
            band        = '0;
            last_err    = '0;
            integ       = '0;
            deriv_mem   = '0;
            drive_q.delete();
            errors      <= 0;
            checked     <= 0;
            outstanding <= 0;
            clamp_hits  <= 0;
        end else begin
            bad  = 0;
            done = 0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pidfd_pkg::REG_GAIN_P:       kp      = cfg_data;
                    pidfd_pkg::REG_GAIN_I:       ki      = cfg_data;
                    pidfd_pkg::REG_GAIN_D:       kd      = cfg_data;
                    pidfd_pkg::REG_INT_BOUND:    int_lim = cfg_data[30:0];
                    pidfd_pkg::REG_DRIVE_UPPER:  hi_lim  = cfg_data;
                    pidfd_pkg::REG_DRIVE_LOWER:  lo_lim  = cfg_data;
                    pidfd_pkg::REG_SMOOTH_COEFF: alpha   = cfg_data[15:0];
                    pidfd_pkg::REG_DEAD_BAND:    band    = cfg_data[30:0];
                    default:                     ;
                endcase
            end
            if (result_valid && result_ready) begin
                got = '{drive, drive_clamped};
                if (drive_q.size() == 0) begin
                    $display("%0t: result with none expected: drive %h clamped %b",
                             $time, drive, drive_clamped);
                    bad++;
                end else begin
                    want = drive_q.pop_front();
                    done = 1;
                    if (got.level !== want.level) begin
                        $display("%0t: drive mismatch: expected %h actual %h",
                                 $time, want.level, got.level);
                        bad++;
                    end
                    if (got.clamped !== want.clamped) begin
                        $display("%0t: drive_clamped mismatch: expected %b actual %b",
                                 $time, want.clamped, got.clamped);
                        bad++;
                    end
                end
            end
            if (sample_valid && sample_ready) begin
                compute_drive(action, error_sample, integral_hold, want);
                drive_q.push_back(want);
            end
            errors      <= errors + bad;
            checked     <= checked + done;
            clamp_hits  <= clamp_hits + ((done != 0 && drive_clamped) ? 1 : 0);
            outstanding <= drive_q.size();
        end
    end

endmodule

[sim/testbench.sv]
// Top of the PID controller testbench: clock, reset, sample and config
// stimulus, receiver stalls and verdict. Depends on pidfd_pkg, the RTL top
// and pid_drive_checker, which does the prediction and comparison.
`timescale 1ns / 100ps

module testbench;

    localparam logic ACT_STEP  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;
    localparam int   IDLE_LIMIT = 5000;
    localparam int   CHOKE_AT   = 400;
    localparam int   CHOKE_LEN  = 400;

    typedef struct packed {
        logic        act;
        logic [31:0] err;
        logic        hold;
    } sample_t;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_ready;
    logic        action;
    logic [31:0] error_sample;
    logic        integral_hold;
    logic        result_valid;
    logic        result_ready;
    logic [31:0] drive;
    logic        drive_clamped;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    int errors, checked, outstanding, clamp_hits;
    int items_sent, clears_sent, holds_sent, settings_used;
    int burst_left;
    int idle_cycles;
    sample_t batch[$];

    pid_controller_filtered_derivative dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .action        (action),
        .error_sample  (error_sample),
        .integral_hold (integral_hold),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .drive         (drive),
        .drive_clamped (drive_clamped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pid_drive_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .action        (action),
        .error_sample  (error_sample),
        .integral_hold (integral_hold),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .drive         (drive),
        .drive_clamped (drive_clamped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .checked       (checked),
        .outstanding   (outstanding),
        .clamp_hits    (clamp_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("** pid_controller_filtered_derivative: FAILED **");
            $finish;
        end
    end

    // receiver: stall patterns that change every stretch, plus one long hold-off
    initial
    begin
        int  mode;
        int  span;
        int  k;
        bit  choked;
        result_ready = 1'b0;
        choked = 1'b0;
        forever begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(16, 200);
            if (!choked && checked >= CHOKE_AT) begin
                choked = 1'b1;
                for (k = 0; k < CHOKE_LEN; k++) begin
                    @(posedge clk);
                    result_ready <= 1'b0;
                end
            end else begin
                for (k = 0; k < span; k++) begin
                    @(posedge clk);
                    case (mode)
                        0, 1:    result_ready <= 1'b1;
                        2:       result_ready <= 1'($urandom_range(0, 1));
                        3:       result_ready <= ($urandom_range(0, 3) == 0);
                        default: result_ready <= (k % 4 == 3);
                    endcase
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] gp, input logic [31:0] gi,
                             input logic [31:0] gd, input logic [31:0] ib,
                             input logic [31:0] up, input logic [31:0] lo,
                             input logic [31:0] sc, input logic [31:0] db);
        write_reg(pidfd_pkg::REG_GAIN_P, gp, 1'b0);
        write_reg(pidfd_pkg::REG_GAIN_I, gi, 1'b0);
        write_reg(pidfd_pkg::REG_GAIN_D, gd, 1'b0);
        write_reg(pidfd_pkg::REG_INT_BOUND, ib, 1'b0);
        write_reg(pidfd_pkg::REG_DRIVE_UPPER, up, 1'b0);
        write_reg(pidfd_pkg::REG_DRIVE_LOWER, lo, 1'b0);
        write_reg(pidfd_pkg::REG_SMOOTH_COEFF, sc, 1'b0);
        write_reg(pidfd_pkg::REG_DEAD_BAND, db, 1'b1);
        settings_used++;
    endtask

    task automatic add_sample(input logic act, input logic [31:0] err, input logic hold);
        batch.push_back('{act, err, hold});
        if (act == ACT_CLEAR)
            clears_sent++;
        else if (hold)
            holds_sent++;
    endtask

    task automatic send_item(input sample_t s, input bit last);
        int gap;
        sample_valid  <= 1'b1;
        action        <= s.act;
        error_sample  <= s.err;
        integral_hold <= s.hold;
        do @(posedge clk); while (!sample_ready);
        items_sent++;
        if (last || burst_left == 0) begin
            sample_valid <= 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            if (!last) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25)
                                                  : $urandom_range(1, 5);
                repeat (gap) @(posedge clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // send the queued items, then drain every result before returning
    task automatic run_batch();
        int i;
        for (i = 0; i < batch.size(); i++)
            send_item(batch[i], i == batch.size() - 1);
        batch.delete();
        do @(posedge clk); while (checked != items_sent);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return $urandom;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_error(input logic [31:0] band_now);
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0001;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            3: begin
                mag = band_now + $urandom_range(0, 2) - 1;
                return $urandom_range(0, 1) ? mag : 32'(0 - mag);
            end
            default: return $urandom_range(0, 32'h0028_0000) - 32'h0014_0000;
        endcase
    endfunction

    initial
    begin
        int          ph;
        int          n;
        logic [31:0] ib, up, lo, sc, db, tmp;
        rst_n         = 1'b0;
        sample_valid  = 1'b0;
        action        = ACT_STEP;
        error_sample  = '0;
        integral_hold = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = pidfd_pkg::REG_GAIN_P;
        cfg_data      = '0;
        burst_left    = 4;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: zero gains and zero integrator bound
        add_sample(ACT_STEP, 32'h0005_0000, 1'b0);
        add_sample(ACT_STEP, 32'h7FFF_FFFF, 1'b0);
        add_sample(ACT_CLEAR, 32'h0000_0000, 1'b0);
        run_batch();

        configure(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h000A_0000,
                  32'h0064_0000, 32'hFF9C_0000, 32'h0000_0000, 32'h0000_0000);
        add_sample(ACT_STEP, 32'h0000_0000, 1'b0);
        add_sample(ACT_STEP, 32'h0003_0000, 1'b0);
        add_sample(ACT_STEP, 32'h0003_0000, 1'b1);
        add_sample(ACT_STEP, 32'hFFFD_8000, 1'b0);
        add_sample(ACT_STEP, 32'h7FFF_FFFF, 1'b0);
        add_sample(ACT_STEP, 32'h8000_0000, 1'b0);
        add_sample(ACT_STEP, 32'h0000_0001, 1'b0);
        add_sample(ACT_STEP, 32'hFFFF_FFFF, 1'b1);
        add_sample(ACT_CLEAR, 32'hA5A5_5A5A, 1'b1);
        add_sample(ACT_STEP, 32'h0032_0000, 1'b0);
        run_batch();

        // extreme gains, full integrator range, heaviest filter, unit dead band
        configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000);
        add_sample(ACT_STEP, 32'h0001_0000, 1'b0);
        add_sample(ACT_STEP, 32'hFFFF_0000, 1'b0);
        add_sample(ACT_STEP, 32'h0001_0001, 1'b0);
        add_sample(ACT_STEP, 32'hFFFE_FFFF, 1'b0);
        add_sample(ACT_STEP, 32'h7FFF_FFFF, 1'b0);
        add_sample(ACT_STEP, 32'h8000_0000, 1'b0);
        add_sample(ACT_STEP, 32'h0000_0000, 1'b1);
        run_batch();

        // crossed output limits, lightest filter, widest dead band
        configure(32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_8000, 32'h0000_0000,
                  32'hFFF6_0000, 32'h000A_0000, 32'h0000_0001, 32'h7FFF_FFFF);
        add_sample(ACT_STEP, 32'h7FFF_FFFF, 1'b0);
        add_sample(ACT_STEP, 32'h8000_0000, 1'b0);
        add_sample(ACT_STEP, 32'h0000_0000, 1'b0);
        add_sample(ACT_STEP, 32'h0005_0000, 1'b1);
        run_batch();

        for (ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 5))
                0:       ib = 32'h0000_0000;
                1:       ib = 32'h7FFF_FFFF;
                default: ib = $urandom_range(0, 32'h0032_0000);
            endcase
            ib[31] = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0: begin
                    up = 32'h7FFF_FFFF;
                    lo = 32'h8000_0000;
                end
                1: begin
                    up = $urandom;
                    lo = $urandom;
                end
                2: begin
                    up = 32'(0 - $urandom_range(0, 32'h0032_0000));
                    lo = $urandom_range(0, 32'h0032_0000);
                end
                3: begin
                    up = $urandom_range(0, 32'h0064_0000) - 32'h0032_0000;
                    lo = up;
                end
                default: begin
                    up = $urandom_range(0, 32'h00C8_0000);
                    lo = 32'(0 - $urandom_range(0, 32'h00C8_0000));
                end
            endcase
            case ($urandom_range(0, 3))
                0:       sc = 32'h0000_0000;
                1:       sc = 32'h0000_FFFF;
                default: sc = $urandom_range(1, 16'hFFFF);
            endcase
            tmp = $urandom;
            sc[31:16] = tmp[31:16];
            case ($urandom_range(0, 9))
                0:          db = 32'h7FFF_FFFF;
                1, 2, 3, 4: db = $urandom_range(1, 32'h0002_0000);
                default:    db = 32'h0000_0000;
            endcase
            db[31] = 1'($urandom_range(0, 1));
            configure(pick_gain(), pick_gain(), pick_gain(), ib, up, lo, sc, db);
            for (n = 0; n < 125; n++)
                add_sample(($urandom_range(0, 24) == 0) ? ACT_CLEAR : ACT_STEP,
                           pick_error({1'b0, db[30:0]}), ($urandom_range(0, 4) == 0));
            run_batch();
        end

        repeat (24) @(posedge clk);
        $display("Ran %0d items (%0d clears, %0d held steps) under %0d register settings.",
                 items_sent, clears_sent, holds_sent, settings_used);
        $display("Checked %0d results, %0d of them at an output limit.", checked, clamp_hits);
        if (errors == 0 && outstanding == 0 && checked == items_sent)
            $display("** pid_controller_filtered_derivative: PASSED **");
        else
            $display("** pid_controller_filtered_derivative: FAILED **");
        $finish;
    end

endmodule
